// ----- src/mmir_pkg.sv -----
// ---------------------------------------------------------------------------
// mmir_pkg - shared types and constants for the run reducer
// Operation codes of the shared fold unit, divider handshake structs,
// mode codes and the 32-bit saturation helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package mmir_pkg;

   // Widths fixed by the data format
   localparam int SAMPLE_W   = 32;
   localparam int ACC_W      = 48;
   localparam int WORD_W     = 64;
   localparam int COUNT_W    = 7;
   localparam int DIV_STEP_W = $clog2(ACC_W);

   // Combine mode codes
   localparam logic [2:0] MODE_SUM     = 3'd0;
   localparam logic [2:0] MODE_PRODUCT = 3'd1;
   localparam logic [2:0] MODE_MIN     = 3'd2;
   localparam logic [2:0] MODE_MAX     = 3'd3;
   localparam logic [2:0] MODE_AVERAGE = 3'd4;

   // Register byte addresses
   localparam logic [2:0] ADDR_COMBINE_MODE = 3'd0;

   // Operations of the shared fold unit
   typedef enum logic [3:0] {
      ALU_PASS,
      ALU_ADD,
      ALU_MIN,
      ALU_MAX,
      ALU_MUL,
      ALU_SCALE,
      ALU_CLAMP,
      ALU_ABS,
      ALU_NEG
   } alu_op_type;

   typedef struct packed {
      alu_op_type                op;
      logic signed [WORD_W-1:0]  a;
      logic signed [WORD_W-1:0]  b;
   } alu_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  y;
      logic                      clip;
   } alu_rsp_type;

   typedef struct packed {
      logic                start;
      logic [ACC_W-1:0]    dividend;
      logic [COUNT_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [ACC_W-1:0]    quotient;
   } div_rsp_type;

   localparam logic signed [WORD_W-1:0] I32_MAX = 64'sd2147483647;
   localparam logic signed [WORD_W-1:0] I32_MIN = -64'sd2147483648;

   // True when a value lies outside the signed 32-bit range
   function automatic logic out_of_range32(input logic signed [WORD_W-1:0] v);
      return (v > I32_MAX) || (v < I32_MIN);
   endfunction

   // Saturate a value to the signed 32-bit range
   function automatic logic signed [SAMPLE_W-1:0] clamp32(
      input logic signed [WORD_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > I32_MAX) begin
         r = 32'sh7fffffff;
      end else if (v < I32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- src/multi_mode_input_reducer_unit.sv -----
// ---------------------------------------------------------------------------
// multi_mode_input_reducer_unit - run reducer over Q16.16 samples
// Folds each run of samples into one saturated result by sum, product,
// minimum, maximum or average, with clip and count-overflow flags.
// ---------------------------------------------------------------------------
// The block takes one sample transaction at a time and is stalled while it
// works on it. Each sample is accepted and then folded; in product mode a
// sample after the seed also passes a rescale step, as the 32x32 multiply
// is registered before the rescale. The closing sample then passes a finish
// step that clips the result and hands it to the output register; in average
// mode the sum is first divided by the count in a one-bit-per-cycle divider
// that yields 48 quotient bits; a negative sum is divided as its magnitude
// and gets its sign restored afterwards. All folding goes through one shared
// ALU under the sequencer. The output register lets a finished result wait
// while the next run starts; only a closing sample waits for it to drain.
`default_nettype none

module multi_mode_input_reducer_unit #(
   parameter int MAX_INPUTS = 64
) (
   input  wire          clock,
   input  wire          reset,
   // sample input
   input  wire          req_valid,
   output logic         req_stall,
   input  wire  [31:0]  req_sample,
   input  wire          req_last,
   // result output
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output logic [31:0]  rsp_result,
   output logic         rsp_saturated,
   output logic         rsp_too_many,
   // configuration
   input  wire          csr_psel,
   input  wire          csr_penable,
   input  wire          csr_pwrite,
   input  wire  [2:0]   csr_paddr,
   input  wire  [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [mmir_pkg::COUNT_W-1:0] MaxCount = mmir_pkg::COUNT_W'(MAX_INPUTS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_SCALE,
      ST_DIV_LOAD,
      ST_DIV_WAIT,
      ST_FIX_SIGN,
      ST_FINISH
   } state_type;

   state_type                               state_ff, state_in;
   logic [2:0]                              mode_ff, mode_in;
   logic [2:0]                              run_mode_ff, run_mode_in;
   logic signed [mmir_pkg::SAMPLE_W-1:0]    sample_ff, sample_in;
   logic                                    last_ff, last_in;
   logic signed [mmir_pkg::ACC_W-1:0]       acc_ff, acc_in;
   logic signed [mmir_pkg::WORD_W-1:0]      prod_ff, prod_in;
   logic [mmir_pkg::COUNT_W-1:0]            count_ff, count_in;
   logic                                    clip_ff, clip_in;
   logic                                    ovf_ff, ovf_in;
   logic                                    neg_ff, neg_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [mmir_pkg::SAMPLE_W-1:0]           result_ff, result_in;
   logic                                    saturated_ff, saturated_in;
   logic                                    too_many_ff, too_many_in;

   mmir_pkg::alu_req_type                   alu_req;
   mmir_pkg::alu_rsp_type                   alu_rsp;
   mmir_pkg::div_req_type                   div_req;
   mmir_pkg::div_rsp_type                   div_rsp;

   logic signed [mmir_pkg::WORD_W-1:0]      acc_ext;
   logic signed [mmir_pkg::WORD_W-1:0]      sample_ext;
   logic                                    csr_write;
   state_type                               after_fold;

   mmir_fold_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   mmir_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign acc_ext    = mmir_pkg::WORD_W'(acc_ff);
   assign sample_ext = mmir_pkg::WORD_W'(sample_ff);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Where a run goes once the current sample is folded
   always_comb begin
      if (!last_ff) begin
         after_fold = ST_IDLE;
      end else if (run_mode_ff == mmir_pkg::MODE_AVERAGE) begin
         after_fold = ST_DIV_LOAD;
      end else begin
         after_fold = ST_FINISH;
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      run_mode_in  = run_mode_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      count_in     = count_ff;
      clip_in      = clip_ff;
      ovf_in       = ovf_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      saturated_in = saturated_ff;
      too_many_in  = too_many_ff;

      alu_req.op   = mmir_pkg::ALU_PASS;
      alu_req.a    = acc_ext;
      alu_req.b    = sample_ext;

      div_req.start    = 1'b0;
      div_req.dividend = alu_rsp.y[mmir_pkg::ACC_W-1:0];
      div_req.divisor  = count_ff;

      // take the configuration write
      if (csr_write && (csr_paddr == mmir_pkg::ADDR_COMBINE_MODE)) begin
         mode_in = csr_pwdata[2:0];
      end

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in   = req_sample;
               last_in     = req_last;
               run_mode_in = mode_ff;
               state_in    = ST_FOLD;
            end
         end

         ST_FOLD: begin
            state_in = after_fold;
            if (count_ff == '0) begin
               // seed the run
               alu_req.op = mmir_pkg::ALU_PASS;
               acc_in     = alu_rsp.y[mmir_pkg::ACC_W-1:0];
               count_in   = mmir_pkg::COUNT_W'(1);
            end else if (count_ff >= MaxCount) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
               case (run_mode_ff)
                  mmir_pkg::MODE_PRODUCT: begin
                     alu_req.op = mmir_pkg::ALU_MUL;
                     prod_in    = alu_rsp.y;
                     clip_in    = clip_ff | alu_rsp.clip;
                     state_in   = ST_SCALE;
                  end
                  mmir_pkg::MODE_MIN: begin
                     alu_req.op = mmir_pkg::ALU_MIN;
                     acc_in     = alu_rsp.y[mmir_pkg::ACC_W-1:0];
                  end
                  mmir_pkg::MODE_MAX: begin
                     alu_req.op = mmir_pkg::ALU_MAX;
                     acc_in     = alu_rsp.y[mmir_pkg::ACC_W-1:0];
                  end
                  default: begin
                     alu_req.op = mmir_pkg::ALU_ADD;
                     acc_in     = alu_rsp.y[mmir_pkg::ACC_W-1:0];
                  end
               endcase
            end
         end

         ST_SCALE: begin
            // rescale the product by 16 bits and saturate
            alu_req.op = mmir_pkg::ALU_SCALE;
            alu_req.a  = prod_ff;
            acc_in     = alu_rsp.y[mmir_pkg::ACC_W-1:0];
            clip_in    = clip_ff | alu_rsp.clip;
            state_in   = after_fold;
         end

         ST_DIV_LOAD: begin
            // divide the magnitude, restore the sign afterwards
            alu_req.op    = mmir_pkg::ALU_ABS;
            div_req.start = 1'b1;
            neg_in        = acc_ff[mmir_pkg::ACC_W-1];
            state_in      = ST_DIV_WAIT;
         end

         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               acc_in   = div_rsp.quotient;
               state_in = neg_ff ? ST_FIX_SIGN : ST_FINISH;
            end
         end

         ST_FIX_SIGN: begin
            alu_req.op = mmir_pkg::ALU_NEG;
            acc_in     = alu_rsp.y[mmir_pkg::ACC_W-1:0];
            state_in   = ST_FINISH;
         end

         ST_FINISH: begin
            // clip and hand over once the output register is free
            alu_req.op = mmir_pkg::ALU_CLAMP;
            if (!rsp_valid_ff || !rsp_stall) begin
               result_in    = alu_rsp.y[mmir_pkg::SAMPLE_W-1:0];
               saturated_in = clip_ff | alu_rsp.clip;
               too_many_in  = ovf_ff;
               rsp_valid_in = 1'b1;
               acc_in       = '0;
               count_in     = '0;
               clip_in      = 1'b0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= mmir_pkg::MODE_SUM;
         acc_ff       <= '0;
         count_ff     <= '0;
         clip_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         clip_ff      <= clip_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      run_mode_ff  <= run_mode_in;
      sample_ff    <= sample_in;
      last_ff      <= last_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      result_ff    <= result_in;
      saturated_ff <= saturated_in;
      too_many_ff  <= too_many_in;
   end

   // Ports
   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result    = result_ff;
   assign rsp_saturated = saturated_ff;
   assign rsp_too_many  = too_many_ff;
   assign csr_pready    = 1'b1;
   assign csr_prdata    = (csr_paddr == mmir_pkg::ADDR_COMBINE_MODE) ? {29'd0, mode_ff} : 32'd0;

endmodule

`default_nettype wire

// ----- src/mmir_fold_alu.sv -----
// ---------------------------------------------------------------------------
// mmir_fold_alu - shared arithmetic unit of the run reducer
// One add, compare, multiply or saturate per cycle, selected by the
// sequencer: fold steps, product rescaling, abs value, sign fix, clipping.
// ---------------------------------------------------------------------------
`default_nettype none

module mmir_fold_alu (
   input  wire mmir_pkg::alu_req_type  alu_req,
   output mmir_pkg::alu_rsp_type       alu_rsp
);

   logic signed [mmir_pkg::SAMPLE_W-1:0] a_sat;
   logic signed [mmir_pkg::SAMPLE_W-1:0] b_low;
   logic signed [mmir_pkg::WORD_W-1:0]   a_shifted;
   logic                                 a_clip;

   // Saturated and rescaled views of operand a
   always_comb begin
      a_sat     = mmir_pkg::clamp32(alu_req.a);
      a_clip    = mmir_pkg::out_of_range32(alu_req.a);
      b_low     = alu_req.b[mmir_pkg::SAMPLE_W-1:0];
      a_shifted = alu_req.a >>> 16;
   end

   // Select the operation
   always_comb begin
      alu_rsp.y    = alu_req.a;
      alu_rsp.clip = 1'b0;
      case (alu_req.op)
         mmir_pkg::ALU_PASS: alu_rsp.y = alu_req.b;
         mmir_pkg::ALU_ADD:  alu_rsp.y = alu_req.a + alu_req.b;
         mmir_pkg::ALU_MIN:  alu_rsp.y = (alu_req.b < alu_req.a) ? alu_req.b : alu_req.a;
         mmir_pkg::ALU_MAX:  alu_rsp.y = (alu_req.b > alu_req.a) ? alu_req.b : alu_req.a;
         mmir_pkg::ALU_MUL: begin
            alu_rsp.y    = mmir_pkg::WORD_W'(a_sat) * mmir_pkg::WORD_W'(b_low);
            alu_rsp.clip = a_clip;
         end
         mmir_pkg::ALU_SCALE: begin
            alu_rsp.y    = mmir_pkg::WORD_W'(mmir_pkg::clamp32(a_shifted));
            alu_rsp.clip = mmir_pkg::out_of_range32(a_shifted);
         end
         mmir_pkg::ALU_CLAMP: begin
            alu_rsp.y    = mmir_pkg::WORD_W'(a_sat);
            alu_rsp.clip = a_clip;
         end
         mmir_pkg::ALU_ABS:  alu_rsp.y = alu_req.a[mmir_pkg::WORD_W-1] ? -alu_req.a : alu_req.a;
         mmir_pkg::ALU_NEG:  alu_rsp.y = -alu_req.a;
         default:            alu_rsp.y = alu_req.a;
      endcase
   end

endmodule

`default_nettype wire

// ----- src/mmir_divider.sv -----
// ---------------------------------------------------------------------------
// mmir_divider - iterative unsigned divider for the run average
// Restoring division of a 48-bit magnitude by the 7-bit sample count,
// one quotient bit per cycle; done pulses once the quotient is final.
// ---------------------------------------------------------------------------
`default_nettype none

module mmir_divider (
   input  wire                         clock,
   input  wire                         reset,
   input  wire mmir_pkg::div_req_type  div_req,
   output mmir_pkg::div_rsp_type       div_rsp
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [mmir_pkg::DIV_STEP_W-1:0]     step_ff;
   logic [mmir_pkg::COUNT_W-1:0]        rem_ff;
   logic [mmir_pkg::ACC_W-1:0]          quo_ff;
   logic [mmir_pkg::COUNT_W-1:0]        divisor_ff;

   logic [mmir_pkg::COUNT_W:0]          trial;
   logic [mmir_pkg::COUNT_W:0]          diff;
   logic                                fits;
   logic [mmir_pkg::COUNT_W-1:0]        rem_in;
   logic [mmir_pkg::ACC_W-1:0]          quo_in;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[mmir_pkg::ACC_W-1]};
      diff   = trial - {1'b0, divisor_ff};
      fits   = (trial >= {1'b0, divisor_ff});
      rem_in = fits ? diff[mmir_pkg::COUNT_W-1:0] : trial[mmir_pkg::COUNT_W-1:0];
      quo_in = {quo_ff[mmir_pkg::ACC_W-2:0], fits};
   end

   // Load on start, then iterate once per bit
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == '0);
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= mmir_pkg::DIV_STEP_W'(mmir_pkg::ACC_W - 1);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
      if (div_req.start) begin
         rem_ff     <= '0;
         quo_ff     <= div_req.dividend;
         divisor_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire
